// ----- src/imh_pkg.sv -----
package imh_pkg;

   localparam int CAPACITY_DEF   = 1024;
   localparam int VALUE_BITS_DEF = 16;
   localparam int KEY_BITS       = 10;
   localparam int KEY_SPACE      = 1024;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DEC    = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_PRESENT = 3'd3;
   localparam logic [2:0] ST_ABSENT  = 3'd4;

   localparam logic [1:0] RD_POS    = 2'd0;
   localparam logic [1:0] RD_POP    = 2'd1;
   localparam logic [1:0] RD_PARENT = 2'd2;
   localparam logic [1:0] RD_CHILD  = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       clr_step;
      logic [1:0] rd_sel;
      logic       ins_setup;
      logic       dec_setup;
      logic       pop_take;
      logic       up_move;
      logic       dn_move;
      logic       place;
      logic       finish;
      logic [2:0] status;
   } imh_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       pos_valid;
      logic       full;
      logic       empty;
      logic       last;
      logic       at_root;
      logic       parent_gt;
      logic       dec_zero;
      logic       no_child;
      logic       child_lt;
      logic       clr_done;
   } imh_sts_type;

endpackage

// ----- src/imh_ctrl.sv -----
module imh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  imh_pkg::imh_sts_type sts,
   output imh_pkg::imh_cmd_type cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LOOK   = 4'd2;
   localparam logic [3:0] S_DEC    = 4'd3;
   localparam logic [3:0] S_POP    = 4'd4;
   localparam logic [3:0] S_UP_RD  = 4'd5;
   localparam logic [3:0] S_UP_CMP = 4'd6;
   localparam logic [3:0] S_DN_RD  = 4'd7;
   localparam logic [3:0] S_DN_CMP = 4'd8;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = imh_pkg::RD_POS;
      cmd.status = imh_pkg::ST_OK;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            unique case (sts.op)
               imh_pkg::OP_INSERT: begin
                  if (sts.pos_valid) begin
                     cmd.finish = 1'b1;
                     cmd.status = imh_pkg::ST_PRESENT;
                     state_in   = S_IDLE;
                  end else if (sts.full) begin
                     cmd.finish = 1'b1;
                     cmd.status = imh_pkg::ST_FULL;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.ins_setup = 1'b1;
                     state_in      = S_UP_RD;
                  end
               end
               imh_pkg::OP_DEC: begin
                  if (!sts.pos_valid) begin
                     cmd.finish = 1'b1;
                     cmd.status = imh_pkg::ST_ABSENT;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.rd_sel = imh_pkg::RD_POS;
                     state_in   = S_DEC;
                  end
               end
               imh_pkg::OP_POP: begin
                  if (sts.empty) begin
                     cmd.finish = 1'b1;
                     cmd.status = imh_pkg::ST_EMPTY;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.rd_sel = imh_pkg::RD_POP;
                     state_in   = S_POP;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_DEC: begin
            if (sts.dec_zero) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.dec_setup = 1'b1;
               state_in      = S_UP_RD;
            end
         end
         S_POP: begin
            cmd.pop_take = 1'b1;
            if (sts.last) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_UP_RD: begin
            if (sts.at_root) begin
               cmd.place  = 1'b1;
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.rd_sel = imh_pkg::RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (sts.parent_gt) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.place  = 1'b1;
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DN_RD: begin
            if (sts.no_child) begin
               cmd.place  = 1'b1;
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.rd_sel = imh_pkg::RD_CHILD;
               state_in   = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (sts.child_lt) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               cmd.place  = 1'b1;
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/imh_datapath.sv -----
module imh_datapath #(
   parameter int CAPACITY   = imh_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = imh_pkg::VALUE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_opcode,
   input  logic [9:0]           req_key_in,
   input  logic [15:0]          req_value_in,
   input  imh_pkg::imh_cmd_type cmd,
   output imh_pkg::imh_sts_type sts,
   output logic                 rsp_strobe,
   output logic [2:0]           rsp_status,
   output logic [9:0]           rsp_out_key,
   output logic [15:0]          rsp_out_value,
   output logic [10:0]          rsp_entry_count
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int KB   = imh_pkg::KEY_BITS;
   localparam int VB   = VALUE_BITS;
   localparam int PADW = AW + 2 - CW;

   logic [KB-1:0] key_mem [CAPACITY];
   logic [VB-1:0] val_mem [CAPACITY];
   logic [AW:0]   pos_mem [imh_pkg::KEY_SPACE];

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [KB-1:0] clr_ff;
   logic [1:0]    op_ff;
   logic [KB-1:0] mov_key_ff, mov_key_in;
   logic [VB-1:0] mov_val_ff, mov_val_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW:0]   pos_q_ff;
   logic [KB-1:0] ha_key_ff, hb_key_ff;
   logic [VB-1:0] ha_val_ff, hb_val_ff;
   logic [KB-1:0] pop_key_ff, pop_key_in;
   logic [VB-1:0] pop_val_ff, pop_val_in;
   logic          rsp_strobe_ff;
   logic [2:0]    rsp_status_ff;
   logic [9:0]    rsp_key_ff;
   logic [15:0]   rsp_val_ff;
   logic [10:0]   rsp_cnt_ff;

   logic [AW-1:0]    addr_a, addr_b, idx_m1, parent;
   logic [AW:0]      c1;
   logic [AW+1:0]    c1_ext, c2_ext, cnt_ext, idx_ext;
   logic             c2_ok, sel_b;
   logic [KB-1:0]    ch_key;
   logic [VB-1:0]    ch_val;
   logic [AW-1:0]    ch_idx;
   logic [CW-1:0]    cnt_m1;
   logic [VB+15:0]   val_in_w, pop_out_w;
   logic [CW+10:0]   cnt_out_w;
   logic             heap_we, pos_we;
   logic [KB-1:0]    heap_wkey, pos_waddr;
   logic [VB-1:0]    heap_wval;
   logic [AW:0]      pos_wdata;

   assign val_in_w = {{VB{1'b0}}, req_value_in};
   assign idx_m1   = idx_ff - AW'(1);
   assign parent   = idx_m1 >> 1;
   assign c1       = {idx_ff, 1'b1};
   assign c1_ext   = {1'b0, c1};
   assign c2_ext   = c1_ext + (AW+2)'(1);
   assign cnt_ext  = {{PADW{1'b0}}, cnt_ff};
   assign idx_ext  = {2'b00, idx_ff};
   assign cnt_m1   = cnt_ff - CW'(1);
   assign c2_ok    = (c2_ext < cnt_ext);
   assign sel_b    = c2_ok && (hb_val_ff < ha_val_ff);
   assign ch_key   = sel_b ? hb_key_ff : ha_key_ff;
   assign ch_val   = sel_b ? hb_val_ff : ha_val_ff;
   assign ch_idx   = sel_b ? c2_ext[AW-1:0] : c1_ext[AW-1:0];

   always_comb begin
      addr_a = idx_ff;
      addr_b = idx_ff;
      unique case (cmd.rd_sel)
         imh_pkg::RD_POS:    addr_a = pos_q_ff[AW-1:0];
         imh_pkg::RD_POP: begin
            addr_a = '0;
            addr_b = cnt_m1[AW-1:0];
         end
         imh_pkg::RD_PARENT: addr_a = parent;
         imh_pkg::RD_CHILD: begin
            addr_a = c1_ext[AW-1:0];
            addr_b = c2_ext[AW-1:0];
         end
         default: addr_a = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ha_key_ff <= key_mem[addr_a];
      ha_val_ff <= val_mem[addr_a];
      hb_key_ff <= key_mem[addr_b];
      hb_val_ff <= val_mem[addr_b];
      if (heap_we) begin
         key_mem[idx_ff] <= heap_wkey;
         val_mem[idx_ff] <= heap_wval;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_q_ff <= pos_mem[req_key_in];
      end
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
   end

   always_comb begin
      heap_we   = cmd.place || cmd.up_move || cmd.dn_move;
      heap_wkey = mov_key_ff;
      heap_wval = mov_val_ff;
      pos_we    = heap_we || cmd.clr_step || cmd.pop_take;
      pos_waddr = mov_key_ff;
      pos_wdata = {1'b1, idx_ff};
      priority if (cmd.clr_step) begin
         pos_waddr = clr_ff;
         pos_wdata = '0;
      end else if (cmd.pop_take) begin
         pos_waddr = ha_key_ff;
         pos_wdata = '0;
      end else if (cmd.up_move) begin
         heap_wkey = ha_key_ff;
         heap_wval = ha_val_ff;
         pos_waddr = ha_key_ff;
      end else if (cmd.dn_move) begin
         heap_wkey = ch_key;
         heap_wval = ch_val;
         pos_waddr = ch_key;
      end
   end

   always_comb begin
      cnt_in     = cnt_ff;
      mov_key_in = mov_key_ff;
      mov_val_in = mov_val_ff;
      idx_in     = idx_ff;
      pop_key_in = pop_key_ff;
      pop_val_in = pop_val_ff;
      priority if (cmd.capture) begin
         mov_key_in = req_key_in;
         mov_val_in = val_in_w[VB-1:0];
         pop_key_in = '0;
         pop_val_in = '0;
      end else if (cmd.ins_setup) begin
         idx_in = cnt_ff[AW-1:0];
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.dec_setup) begin
         idx_in     = pos_q_ff[AW-1:0];
         mov_val_in = ha_val_ff - VB'(1);
      end else if (cmd.pop_take) begin
         pop_key_in = ha_key_ff;
         pop_val_in = ha_val_ff;
         cnt_in     = cnt_m1;
         mov_key_in = hb_key_ff;
         mov_val_in = hb_val_ff;
         idx_in     = '0;
      end else if (cmd.up_move) begin
         idx_in = parent;
      end else if (cmd.dn_move) begin
         idx_in = ch_idx;
      end
   end

   assign pop_out_w = {16'b0, pop_val_in};
   assign cnt_out_w = {11'b0, cnt_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         clr_ff        <= cmd.clr_step ? clr_ff + KB'(1) : clr_ff;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_opcode;
      end
      mov_key_ff <= mov_key_in;
      mov_val_ff <= mov_val_in;
      idx_ff     <= idx_in;
      pop_key_ff <= pop_key_in;
      pop_val_ff <= pop_val_in;
      if (cmd.finish) begin
         rsp_status_ff <= cmd.status;
         rsp_key_ff    <= pop_key_in;
         rsp_val_ff    <= pop_out_w[15:0];
         rsp_cnt_ff    <= cnt_out_w[10:0];
      end
   end

   assign sts.op        = op_ff;
   assign sts.pos_valid = pos_q_ff[AW];
   assign sts.full      = (cnt_ff == CW'(CAPACITY));
   assign sts.empty     = (cnt_ff == '0);
   assign sts.last      = (cnt_ff == CW'(1));
   assign sts.at_root   = (idx_ff == '0);
   assign sts.parent_gt = (ha_val_ff > mov_val_ff);
   assign sts.dec_zero  = (ha_val_ff == '0);
   assign sts.no_child  = (c1_ext >= cnt_ext);
   assign sts.child_lt  = (ch_val < mov_val_ff);
   assign sts.clr_done  = (clr_ff == {KB{1'b1}});

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_value   = rsp_val_ff;
   assign rsp_entry_count = rsp_cnt_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ext <= (AW+2)'(CAPACITY))
      else $error("entry count above capacity");
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("back to back result strobes");
   a_write_slot: assert property (@(posedge clock) disable iff (reset)
      heap_we |-> (idx_ext < cnt_ext))
      else $error("heap write beyond filled slots");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_take |-> (cnt_ff != '0))
      else $error("pop from empty heap");
`endif

endmodule

// ----- src/indexed_min_heap_unit.sv -----
// each sift level is one heap memory read, then a compare and write back
// one transaction at a time; the next one is accepted in the strobe cycle at the earliest
// reset: synchronous; a sweep then clears all 1024 entries of the key position table with busy high
// the result strobe lasts one cycle and the receiver cannot stall
module indexed_min_heap_unit #(
   parameter int CAPACITY   = imh_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = imh_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [9:0]  req_key_in,
   input  logic [15:0] req_value_in,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_out_key,
   output logic [15:0] rsp_out_value,
   output logic [10:0] rsp_entry_count
);

   imh_pkg::imh_cmd_type cmd;
   imh_pkg::imh_sts_type sts;

   imh_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   imh_datapath #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_key_in      (req_key_in),
      .req_value_in    (req_value_in),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_value   (rsp_out_value),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ----- dv/indexed_min_heap_unit_test.sv -----
`timescale 1ns / 100ps

class heap_scoreboard;
   typedef struct {
      logic [2:0]  status;
      logic [9:0]  key;
      logic [15:0] value;
      logic [10:0] count;
   } heap_reply_type;

   logic [9:0]  slot_key [0:1023];
   logic [15:0] slot_val [0:1023];
   int          key_slot [0:1023];
   bit          key_live [0:1023];
   int          fill;
   heap_reply_type pending [$];
   int          mismatches;

   function new();
      fill = 0;
      mismatches = 0;
      foreach (key_live[i]) begin
         key_live[i] = 0;
         key_slot[i] = 0;
      end
   endfunction

   function void swap_slots(int a, int b);
      logic [9:0]  k;
      logic [15:0] v;
      k = slot_key[a];
      v = slot_val[a];
      slot_key[a] = slot_key[b];
      slot_val[a] = slot_val[b];
      slot_key[b] = k;
      slot_val[b] = v;
      key_slot[slot_key[a]] = a;
      key_slot[slot_key[b]] = b;
   endfunction

   function void sift_toward_root(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (slot_val[p] > slot_val[i]) begin
            swap_slots(i, p);
            i = p;
         end else begin
            break;
         end
      end
   endfunction

   function void sift_from_root();
      int i;
      int c1;
      int c;
      i = 0;
      forever begin
         c1 = 2 * i + 1;
         if (c1 >= fill) break;
         c = (c1 + 1 < fill && slot_val[c1 + 1] < slot_val[c1]) ? c1 + 1 : c1;
         if (slot_val[c] < slot_val[i]) begin
            swap_slots(i, c);
            i = c;
         end else begin
            break;
         end
      end
   endfunction

   function void note_transaction(logic [1:0] op, logic [9:0] key, logic [15:0] value);
      heap_reply_type r;
      int s;
      r.status = imh_pkg::ST_OK;
      r.key = '0;
      r.value = '0;
      case (op)
         imh_pkg::OP_INSERT: begin
            if (key_live[key]) r.status = imh_pkg::ST_PRESENT;
            else if (fill >= 1024) r.status = imh_pkg::ST_FULL;
            else begin
               s = fill;
               fill++;
               slot_key[s] = key;
               slot_val[s] = value;
               key_slot[key] = s;
               key_live[key] = 1;
               sift_toward_root(s);
            end
         end
         imh_pkg::OP_DEC: begin
            if (!key_live[key]) r.status = imh_pkg::ST_ABSENT;
            else begin
               s = key_slot[key];
               if (s < fill && slot_val[s] > 0) begin
                  slot_val[s] = slot_val[s] - 16'd1;
                  sift_toward_root(s);
               end
            end
         end
         imh_pkg::OP_POP: begin
            if (fill == 0) r.status = imh_pkg::ST_EMPTY;
            else begin
               r.key = slot_key[0];
               r.value = slot_val[0];
               key_live[slot_key[0]] = 0;
               fill--;
               if (fill > 0) begin
                  slot_key[0] = slot_key[fill];
                  slot_val[0] = slot_val[fill];
                  key_slot[slot_key[0]] = 0;
                  sift_from_root();
               end
            end
         end
         default: ;
      endcase
      r.count = 11'(fill);
      pending.insert(pending.size(), r);
   endfunction

   function void check_reply(logic [2:0] st, logic [9:0] k, logic [15:0] v, logic [10:0] n);
      heap_reply_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result status %0d key %0d", st, k);
         return;
      end
      e = pending.pop_front();
      if (st !== e.status || k !== e.key || v !== e.value || n !== e.count) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch exp st %0d key %0d val %0d cnt %0d got %0d %0d %0d %0d",
               e.status, e.key, e.value, e.count, st, k, v, n);
      end
   endfunction
endclass

module indexed_min_heap_unit_test;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_opcode = imh_pkg::OP_INSERT;
   logic [9:0]  req_key_in = '0;
   logic [15:0] req_value_in = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_out_key;
   logic [15:0] rsp_out_value;
   logic [10:0] rsp_entry_count;

   heap_scoreboard board = new();
   int idle_pct = 0;

   indexed_min_heap_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && start && !busy) board.note_transaction(req_opcode, req_key_in, req_value_in);
      if (!reset && rsp_strobe)
         board.check_reply(rsp_status, rsp_out_key, rsp_out_value, rsp_entry_count);
   end

   // one transaction, with random idle cycles before it
   task automatic issue(logic [1:0] op, logic [9:0] key, logic [15:0] value);
      @(posedge clock);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1;
      req_opcode <= op;
      req_key_in <= key;
      req_value_in <= value;
      do @(posedge clock); while (busy);
      start <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic random_ops(int n, int key_range);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 40)
            issue(imh_pkg::OP_INSERT, 10'($urandom_range(key_range)), 16'($urandom));
         else if (r < 70)
            issue(imh_pkg::OP_DEC, 10'($urandom_range(key_range)), 16'($urandom));
         else if (r < 97) issue(imh_pkg::OP_POP, 10'($urandom), 16'($urandom));
         else issue(OP_UNUSED, 10'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      issue(imh_pkg::OP_POP, 10'd5, 16'd0);
      issue(imh_pkg::OP_DEC, 10'd7, 16'd0);
      issue(imh_pkg::OP_INSERT, 10'd1023, 16'hffff);
      issue(imh_pkg::OP_INSERT, 10'd1023, 16'd3);
      issue(imh_pkg::OP_INSERT, 10'd0, 16'd0);
      issue(imh_pkg::OP_INSERT, 10'd7, 16'd1);
      issue(imh_pkg::OP_INSERT, 10'd8, 16'd1);
      issue(imh_pkg::OP_DEC, 10'd0, 16'd0);
      issue(imh_pkg::OP_DEC, 10'd7, 16'd0);
      issue(imh_pkg::OP_DEC, 10'd1023, 16'd0);
      issue(OP_UNUSED, 10'h3ff, 16'hffff);
      repeat (5) issue(imh_pkg::OP_POP, 10'h3ff, 16'hffff);
      issue(imh_pkg::OP_DEC, 10'd8, 16'd0);
      drain();
      // fill to capacity, then work on a full heap
      for (int k = 0; k < 1024; k++) issue(imh_pkg::OP_INSERT, 10'(k), 16'($urandom));
      issue(imh_pkg::OP_INSERT, 10'd5, 16'd1);
      for (int k = 0; k < 20; k++) issue(imh_pkg::OP_DEC, 10'($urandom), 16'd0);
      drain();
      // random phases
      idle_pct = 0;  random_ops(40, 63);
      idle_pct = 57; random_ops(40, 1023);
      drain();
      idle_pct = 10; random_ops(40, 31);
      idle_pct = 0;  random_ops(40, 255);
      drain();
      if (board.mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end
endmodule

// ----- files.f -----
src/imh_pkg.sv
src/imh_ctrl.sv
src/imh_datapath.sv
src/indexed_min_heap_unit.sv
dv/indexed_min_heap_unit_test.sv
